### rtl/vga_irf_pkg.sv
// Shared types and constants for the VGA indexed register file.
// Port offsets, access codes, palette sizing and the request/result structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vga_irf_pkg;

   localparam int PALETTE_COLOURS = 256;
   localparam int PAL_DEPTH       = PALETTE_COLOURS * 3;
   localparam int PAL_AW          = $clog2(PAL_DEPTH);

   localparam int PORT_W = 10;
   localparam int DATA_W = 8;
   localparam int PTR_W  = 10;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [PORT_W-1:0] PORT_ATTR      = 10'h3c0;
   localparam logic [PORT_W-1:0] PORT_MISC      = 10'h3c2;
   localparam logic [PORT_W-1:0] PORT_SUBSYS    = 10'h3c3;
   localparam logic [PORT_W-1:0] PORT_SEQ_IDX   = 10'h3c4;
   localparam logic [PORT_W-1:0] PORT_SEQ_DATA  = 10'h3c5;
   localparam logic [PORT_W-1:0] PORT_DAC_MASK  = 10'h3c6;
   localparam logic [PORT_W-1:0] PORT_DAC_RIDX  = 10'h3c7;
   localparam logic [PORT_W-1:0] PORT_DAC_WIDX  = 10'h3c8;
   localparam logic [PORT_W-1:0] PORT_DAC_DATA  = 10'h3c9;
   localparam logic [PORT_W-1:0] PORT_FEATURE   = 10'h3ca;
   localparam logic [PORT_W-1:0] PORT_GFX_IDX   = 10'h3ce;
   localparam logic [PORT_W-1:0] PORT_GFX_DATA  = 10'h3cf;
   localparam logic [PORT_W-1:0] PORT_STATUS    = 10'h3da;

   localparam logic [DATA_W-1:0] DAC_MASK_ON    = 8'hFF;
   localparam logic [DATA_W-1:0] BUS_ERR_DATA   = 8'hFF;
   localparam logic [DATA_W-1:0] SUBSYS_ON      = 8'h01;
   localparam logic [DATA_W-1:0] UNHANDLED_DATA = 8'h01;
   localparam logic [DATA_W-1:0] SUBSYS_RESET   = 8'h01;
   localparam logic [2:0]        SEQ_MEM_MODE   = 3'd4;
   localparam logic [2:0]        SEQ_VGA_MODE   = 3'd7;

   typedef struct packed {
      logic              op;
      logic [PORT_W-1:0] port_offset;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              bus_error;
      logic              mode_change;
      logic              subsystem_enabled;
      logic              vga_mode_bit;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [PAL_AW-1:0] addr;
      logic [DATA_W-1:0] data;
   } pal_wr_type;

endpackage

`default_nettype wire

### rtl/vga_irf_pal_ram.sv
// Palette DAC storage: one write port, one registered read port.
// A write to the address being read is forwarded to the read data.
// Depends on vga_irf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vga_irf_pal_ram (
   input  wire                                   clock,
   input  wire vga_irf_pkg::pal_wr_type          wr,
   input  wire  [vga_irf_pkg::PAL_AW-1:0]        raddr,
   output logic [vga_irf_pkg::DATA_W-1:0]        rdata_ff
);

   logic [vga_irf_pkg::DATA_W-1:0] mem [vga_irf_pkg::PAL_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (wr.en && wr.addr == raddr) begin
         rdata_ff <= wr.data;
      end else begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### rtl/vga_irf_regs.sv
// Register banks and port decode: graphics, sequencer, attribute and DAC
// state, plus the result of one access. Depends on vga_irf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vga_irf_regs (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                advance,
   input  wire vga_irf_pkg::req_type          req,
   input  wire                                host_allowed,
   input  wire  [vga_irf_pkg::DATA_W-1:0]     pal_rdata,
   output vga_irf_pkg::rsp_type               rsp,
   output vga_irf_pkg::pal_wr_type            pal_wr,
   output logic [vga_irf_pkg::PAL_AW-1:0]     pal_raddr
);

   localparam logic [vga_irf_pkg::PTR_W-1:0] PAL_LIMIT =
      vga_irf_pkg::PTR_W'(vga_irf_pkg::PAL_DEPTH);

   logic [3:0]                      gfx_index_ff, gfx_index_in;
   logic [vga_irf_pkg::DATA_W-1:0]  gfx_regs_ff [16];
   logic [2:0]                      seq_index_ff, seq_index_in;
   logic                            attr_phase_ff, attr_phase_in;
   logic [4:0]                      attr_index_ff, attr_index_in;
   logic [vga_irf_pkg::DATA_W-1:0]  subsys_ff, subsys_in;
   logic                            enable_ff, enable_in;
   logic                            vga_mode_ff, vga_mode_in;
   logic                            dac_we_ff, dac_we_in;
   logic [vga_irf_pkg::PTR_W-1:0]   dac_wp_ff, dac_wp_in;
   logic [vga_irf_pkg::PTR_W-1:0]   dac_rp_ff, dac_rp_in;
   logic                            gfx_wr;
   logic [vga_irf_pkg::PTR_W-1:0]   ptr_x3;
   logic [vga_irf_pkg::DATA_W-1:0]  v;
   logic                            is_wr;

   assign v      = req.write_data;
   assign is_wr  = (req.op == vga_irf_pkg::OP_WRITE);
   assign ptr_x3 = {1'b0, v, 1'b0} + {2'b00, v};

   always_comb begin
      gfx_index_in  = gfx_index_ff;
      seq_index_in  = seq_index_ff;
      attr_phase_in = attr_phase_ff;
      attr_index_in = attr_index_ff;
      subsys_in     = subsys_ff;
      enable_in     = enable_ff;
      vga_mode_in   = vga_mode_ff;
      dac_we_in     = dac_we_ff;
      dac_wp_in     = dac_wp_ff;
      dac_rp_in     = dac_rp_ff;
      gfx_wr        = 1'b0;
      pal_wr.en     = 1'b0;
      pal_wr.addr   = dac_wp_ff[vga_irf_pkg::PAL_AW-1:0];
      pal_wr.data   = v;
      rsp.read_data   = '0;
      rsp.bus_error   = 1'b0;
      rsp.mode_change = 1'b0;
      if (!is_wr) begin
         rsp.read_data = vga_irf_pkg::UNHANDLED_DATA;
         case (req.port_offset)
            vga_irf_pkg::PORT_ATTR:     rsp.read_data = {3'b000, attr_index_ff};
            vga_irf_pkg::PORT_MISC,
            vga_irf_pkg::PORT_FEATURE:  rsp.read_data = '0;
            vga_irf_pkg::PORT_SUBSYS: begin
               if (!enable_ff && !host_allowed) begin
                  rsp.read_data = vga_irf_pkg::BUS_ERR_DATA;
                  rsp.bus_error = 1'b1;
               end else begin
                  rsp.read_data = subsys_ff;
               end
            end
            vga_irf_pkg::PORT_DAC_DATA:
               rsp.read_data = (dac_rp_ff < PAL_LIMIT) ? pal_rdata : '0;
            vga_irf_pkg::PORT_GFX_IDX:  rsp.read_data = {4'h0, gfx_index_ff};
            vga_irf_pkg::PORT_GFX_DATA: rsp.read_data = gfx_regs_ff[gfx_index_ff];
            vga_irf_pkg::PORT_STATUS: begin
               rsp.read_data = {7'd0, enable_ff};
               attr_phase_in = 1'b0;
            end
            default: ;
         endcase
      end else begin
         case (req.port_offset)
            vga_irf_pkg::PORT_GFX_IDX:  gfx_index_in = v[3:0];
            vga_irf_pkg::PORT_GFX_DATA: gfx_wr = 1'b1;
            vga_irf_pkg::PORT_SEQ_IDX:  seq_index_in = v[2:0];
            vga_irf_pkg::PORT_SEQ_DATA: begin
               rsp.mode_change = (seq_index_ff == vga_irf_pkg::SEQ_MEM_MODE);
               if (seq_index_ff == vga_irf_pkg::SEQ_VGA_MODE) begin
                  vga_mode_in = v[7];
               end
            end
            vga_irf_pkg::PORT_SUBSYS: begin
               enable_in = (v == vga_irf_pkg::SUBSYS_ON);
               subsys_in = v;
            end
            vga_irf_pkg::PORT_DAC_MASK: dac_we_in = (v == vga_irf_pkg::DAC_MASK_ON);
            vga_irf_pkg::PORT_DAC_RIDX: dac_rp_in = ptr_x3;
            vga_irf_pkg::PORT_DAC_WIDX: dac_wp_in = ptr_x3;
            vga_irf_pkg::PORT_DAC_DATA: begin
               if (dac_we_ff) begin
                  pal_wr.en = (dac_wp_ff < PAL_LIMIT);
                  dac_wp_in = dac_wp_ff + 1'b1;
               end
            end
            vga_irf_pkg::PORT_ATTR: begin
               if (!attr_phase_ff) begin
                  attr_index_in = v[4:0];
               end
               attr_phase_in = ~attr_phase_ff;
            end
            default: ;
         endcase
      end
      if (!advance) begin
         gfx_index_in  = gfx_index_ff;
         seq_index_in  = seq_index_ff;
         attr_phase_in = attr_phase_ff;
         attr_index_in = attr_index_ff;
         subsys_in     = subsys_ff;
         enable_in     = enable_ff;
         vga_mode_in   = vga_mode_ff;
         dac_we_in     = dac_we_ff;
         dac_wp_in     = dac_wp_ff;
         dac_rp_in     = dac_rp_ff;
         gfx_wr        = 1'b0;
         pal_wr.en     = 1'b0;
      end
      rsp.subsystem_enabled = enable_in;
      rsp.vga_mode_bit      = vga_mode_in;
      pal_raddr             = dac_rp_in[vga_irf_pkg::PAL_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gfx_index_ff  <= '0;
         seq_index_ff  <= '0;
         attr_phase_ff <= 1'b0;
         attr_index_ff <= '0;
         subsys_ff     <= vga_irf_pkg::SUBSYS_RESET;
         enable_ff     <= 1'b0;
         vga_mode_ff   <= 1'b1;
         dac_we_ff     <= 1'b0;
         dac_wp_ff     <= '0;
         dac_rp_ff     <= '0;
         for (int i = 0; i < 16; i++) begin
            gfx_regs_ff[i] <= '0;
         end
      end else begin
         gfx_index_ff  <= gfx_index_in;
         seq_index_ff  <= seq_index_in;
         attr_phase_ff <= attr_phase_in;
         attr_index_ff <= attr_index_in;
         subsys_ff     <= subsys_in;
         enable_ff     <= enable_in;
         vga_mode_ff   <= vga_mode_in;
         dac_we_ff     <= dac_we_in;
         dac_wp_ff     <= dac_wp_in;
         dac_rp_ff     <= dac_rp_in;
         if (gfx_wr) begin
            gfx_regs_ff[gfx_index_ff] <= v;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/vga_indexed_register_file.sv
// VGA indexed register file top level: request register, decode/banks,
// palette RAM with its clearing pass, and the result register.
// The request register feeds the result register. Throughput: one request
// per cycle while rsp_tready is high and no clear runs; the request register
// and the result register are each a single stage, the palette read is
// registered. Reset: synchronous; then all PALETTE_COLOURS*3 (768) palette
// entries are cleared with req_tready low; csr writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module vga_indexed_register_file (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [9:0] port_offset, [17:10] write_data
   input  wire         req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] read_data, [8] bus_error,
                                    // [9] mode_change, [10] subsystem_enabled,
                                    // [11] vga_mode_bit
   input  wire         csr_tvalid,
   output logic        csr_tready,
   input  wire  [7:0]  csr_tdata    // [0] host_graphics_allowed
);

   localparam logic [vga_irf_pkg::PAL_AW-1:0] CLR_LAST =
      vga_irf_pkg::PAL_AW'(vga_irf_pkg::PAL_DEPTH - 1);

   vga_irf_pkg::req_type    req_ff;
   logic                    req_valid_ff;
   vga_irf_pkg::rsp_type    rsp_ff, rsp_in;
   logic                    rsp_valid_ff;
   logic                    host_allowed_ff;
   logic                    clearing_ff;
   logic [vga_irf_pkg::PAL_AW-1:0] clr_ff;
   logic                    advance;
   logic                    req_take;
   vga_irf_pkg::pal_wr_type pal_wr, ram_wr;
   logic [vga_irf_pkg::PAL_AW-1:0] pal_raddr;
   logic [vga_irf_pkg::DATA_W-1:0] pal_rdata;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clearing_ff && (!req_valid_ff || advance);
   assign req_take   = req_tvalid && req_tready;
   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_ff.vga_mode_bit, rsp_ff.subsystem_enabled,
                        rsp_ff.mode_change, rsp_ff.bus_error, rsp_ff.read_data};

   always_comb begin
      ram_wr = pal_wr;
      if (clearing_ff) begin
         ram_wr.en   = 1'b1;
         ram_wr.addr = clr_ff;
         ram_wr.data = '0;
      end
   end

   vga_irf_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req          (req_ff),
      .host_allowed (host_allowed_ff),
      .pal_rdata    (pal_rdata),
      .rsp          (rsp_in),
      .pal_wr       (pal_wr),
      .pal_raddr    (pal_raddr)
   );

   vga_irf_pal_ram u_pal_ram (
      .clock    (clock),
      .wr       (ram_wr),
      .raddr    (pal_raddr),
      .rdata_ff (pal_rdata)
   );

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.op          <= req_tuser;
         req_ff.port_offset <= req_tdata[9:0];
         req_ff.write_data  <= req_tdata[17:10];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         host_allowed_ff <= 1'b0;
         clearing_ff     <= 1'b1;
         clr_ff          <= '0;
      end else begin
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_tvalid) begin
            host_allowed_ff <= csr_tdata[0];
         end
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               clearing_ff <= 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

### verif/tb_vga_indexed_register_file.sv
// Self-checking testbench for vga_indexed_register_file: port window reads and
// writes are checked against an in-bench predictor of the register banks.
// Depends on rtl/vga_irf_pkg.sv and rtl/vga_indexed_register_file.sv.
`timescale 1ns / 1ps

module tb_vga_indexed_register_file;
   import vga_irf_pkg::*;

   localparam logic [PORT_W-1:0] PORT_UNLOCK    = 10'h3bf;
   localparam logic [PORT_W-1:0] PORT_CRT_IDX   = 10'h3d4;
   localparam logic [PORT_W-1:0] PORT_CRT_DATA  = 10'h3d5;
   localparam logic [PORT_W-1:0] PORT_DISP_MODE = 10'h3d8;
   localparam logic [DATA_W-1:0] UNLOCK_KEY_A   = 8'h03;
   localparam logic [DATA_W-1:0] UNLOCK_KEY_B   = 8'hA0;
   localparam logic [7:0] CRT_LOCK_BASE = 8'h18;
   localparam logic [7:0] CRT_OPEN_END  = 8'h32;
   localparam logic [7:0] CRT_OPEN_A    = 8'h33;
   localparam logic [7:0] CRT_OPEN_B    = 8'h35;
   localparam logic [7:0] CRT_SYS_ONE   = 8'h36;
   localparam logic [7:0] CRT_SYS_TWO   = 8'h37;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int RANDOM_PER_PHASE = 382;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [7:0]  csr_tdata = '0;

   vga_indexed_register_file i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted register state
   bit              host_allowed;
   logic [3:0]      gfx_idx;
   logic [7:0]      gfx_bank [16];
   logic [2:0]      seq_idx;
   logic [7:0]      seq_bank [8];
   bit              attr_phase;
   logic [4:0]      attr_idx;
   logic [7:0]      attr_bank [32];
   bit              attr_pal;
   logic [7:0]      crt_idx;
   logic [7:0]      crt_bank [256];
   bit              crt_unlocked;
   logic [7:0]      misc_reg, subsys_reg, disp_mode, sys_cfg_one, sys_cfg_two;
   bit              enabled, vga_mode, dac_wr_en;
   logic [PTR_W-1:0] dac_wptr, dac_rptr;
   logic [7:0]      palette [PAL_DEPTH];

   req_type access_queue [$];
   rsp_type pending_responses [$];
   int      err_count = 0;
   int      req_count = 0;
   int      rsp_count = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      req_fired = 1'b0;
   bit      pressure_go = 1'b0;
   bit      long_hold = 1'b0;
   logic [7:0] last_widx = '0;

   task automatic clear_model();
      host_allowed = 1'b0;
      gfx_idx = '0;  seq_idx = '0;  attr_phase = 1'b0;  attr_idx = '0;
      attr_pal = 1'b0;  crt_idx = '0;  crt_unlocked = 1'b0;
      misc_reg = '0;  subsys_reg = SUBSYS_RESET;  disp_mode = '0;
      sys_cfg_one = '0;  sys_cfg_two = '0;
      enabled = 1'b0;  vga_mode = 1'b1;  dac_wr_en = 1'b0;
      dac_wptr = '0;  dac_rptr = '0;
      foreach (gfx_bank[i]) gfx_bank[i] = '0;
      foreach (seq_bank[i]) seq_bank[i] = '0;
      foreach (attr_bank[i]) attr_bank[i] = '0;
      foreach (crt_bank[i]) crt_bank[i] = '0;
      foreach (palette[i]) palette[i] = '0;
   endtask

   function automatic rsp_type predict_access(req_type r);
      rsp_type    res;
      logic [7:0] v;
      v = r.write_data;
      res = '0;
      if (r.op == OP_READ) begin
         res.read_data = UNHANDLED_DATA;
         case (r.port_offset)
            PORT_ATTR:    res.read_data = {3'b0, attr_idx};
            PORT_MISC,
            PORT_FEATURE: res.read_data = '0;
            PORT_SUBSYS: begin
               if (!enabled && !host_allowed) begin
                  res.read_data = BUS_ERR_DATA;
                  res.bus_error = 1'b1;
               end else begin
                  res.read_data = subsys_reg;
               end
            end
            PORT_DAC_DATA: res.read_data = (dac_rptr < PAL_DEPTH) ? palette[dac_rptr] : '0;
            PORT_GFX_IDX:  res.read_data = {4'b0, gfx_idx};
            PORT_GFX_DATA: res.read_data = gfx_bank[gfx_idx];
            PORT_STATUS: begin
               res.read_data = {7'b0, enabled};
               attr_phase = 1'b0;
            end
            default: ;
         endcase
      end else begin
         case (r.port_offset)
            PORT_UNLOCK:   if (v == UNLOCK_KEY_A) crt_unlocked = 1'b1;
            PORT_GFX_IDX:  gfx_idx = v[3:0];
            PORT_GFX_DATA: gfx_bank[gfx_idx] = v;
            PORT_SEQ_IDX:  seq_idx = v[2:0];
            PORT_SEQ_DATA: begin
               if (seq_idx == SEQ_MEM_MODE) res.mode_change = 1'b1;
               if (seq_idx == SEQ_VGA_MODE) vga_mode = v[7];
               seq_bank[seq_idx] = v;
            end
            PORT_MISC: misc_reg = v;
            PORT_SUBSYS: begin
               enabled = (v == SUBSYS_ON);
               subsys_reg = v;
            end
            PORT_DAC_MASK: dac_wr_en = (v == DAC_MASK_ON);
            PORT_DAC_RIDX: dac_rptr = PTR_W'({2'b0, v} * 10'd3);
            PORT_DAC_WIDX: dac_wptr = PTR_W'({2'b0, v} * 10'd3);
            PORT_DAC_DATA: begin
               if (dac_wr_en) begin
                  if (dac_wptr < PAL_DEPTH) palette[dac_wptr] = v;
                  dac_wptr = dac_wptr + 1'b1;
               end
            end
            PORT_ATTR: begin
               if (!attr_phase) attr_idx = v[4:0];
               else attr_bank[attr_idx] = v;
               attr_phase = !attr_phase;
               attr_pal = v[5];
            end
            PORT_CRT_IDX: crt_idx = v;
            PORT_CRT_DATA: begin
               if (crt_idx < CRT_OPEN_END || crt_idx == CRT_OPEN_A || crt_idx == CRT_OPEN_B ||
                   (crt_idx > CRT_LOCK_BASE && crt_unlocked))
                  crt_bank[crt_idx] = v;
               if (crt_idx == CRT_SYS_ONE && crt_unlocked) sys_cfg_one = v;
               if (crt_idx == CRT_SYS_TWO && crt_unlocked) sys_cfg_two = v;
            end
            PORT_DISP_MODE: begin
               if (v == UNLOCK_KEY_B) crt_unlocked = 1'b1;
               else disp_mode = v;
            end
            default: ;
         endcase
      end
      res.subsystem_enabled = enabled;
      res.vga_mode_bit = vga_mode;
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s: got 0x%02h, expected 0x%02h",
                                   rsp_count, name, got, want));
   endtask

   task automatic push_access(logic op, logic [PORT_W-1:0] port, logic [7:0] data);
      req_type r;
      r.op = op;
      r.port_offset = port;
      r.write_data = data;
      access_queue.push_back(r);
   endtask

   function automatic logic [PORT_W-1:0] pick_decoded_port();
      case ($urandom_range(16))
         0:  return PORT_ATTR;
         1:  return PORT_MISC;
         2:  return PORT_SUBSYS;
         3:  return PORT_SEQ_IDX;
         4:  return PORT_SEQ_DATA;
         5:  return PORT_DAC_MASK;
         6:  return PORT_DAC_RIDX;
         7:  return PORT_DAC_WIDX;
         8:  return PORT_DAC_DATA;
         9:  return PORT_FEATURE;
         10: return PORT_GFX_IDX;
         11: return PORT_GFX_DATA;
         12: return PORT_STATUS;
         13: return PORT_UNLOCK;
         14: return PORT_CRT_IDX;
         15: return PORT_CRT_DATA;
         default: return PORT_DISP_MODE;
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   // one register-level sequence with random content, or noise
   task automatic add_random_burst();
      int n;
      n = 0;
      case ($urandom_range(9))
         0: begin
            push_access(OP_WRITE, PORT_GFX_IDX, rand_byte());
            push_access(OP_WRITE, PORT_GFX_DATA, rand_byte());
            push_access(OP_READ, PORT_GFX_DATA, rand_byte());
            push_access(OP_READ, PORT_GFX_IDX, rand_byte());
         end
         1: begin
            push_access(OP_WRITE, PORT_SEQ_IDX, rand_byte());
            push_access(OP_WRITE, PORT_SEQ_DATA, rand_byte());
         end
         2: begin
            push_access(OP_WRITE, PORT_DAC_MASK,
                        ($urandom_range(3) != 0) ? DAC_MASK_ON : rand_byte());
            last_widx = rand_byte();
            push_access(OP_WRITE, PORT_DAC_WIDX, last_widx);
            n = $urandom_range(1, 6);
            repeat (n) push_access(OP_WRITE, PORT_DAC_DATA, rand_byte());
         end
         3: begin
            push_access(OP_WRITE, PORT_DAC_RIDX, $urandom_range(1) ? last_widx : rand_byte());
            push_access(OP_READ, PORT_DAC_DATA, rand_byte());
         end
         4: begin
            if ($urandom_range(3) != 0) push_access(OP_READ, PORT_STATUS, rand_byte());
            push_access(OP_WRITE, PORT_ATTR, rand_byte());
            push_access(OP_WRITE, PORT_ATTR, rand_byte());
            push_access(OP_READ, PORT_ATTR, rand_byte());
         end
         5: begin
            push_access(OP_WRITE, PORT_SUBSYS, $urandom_range(1) ? SUBSYS_ON : rand_byte());
            push_access(OP_READ, PORT_SUBSYS, rand_byte());
            push_access(OP_READ, PORT_STATUS, rand_byte());
         end
         6: begin
            if ($urandom_range(3) == 0)
               push_access(OP_WRITE, $urandom_range(1) ? PORT_UNLOCK : PORT_DISP_MODE,
                           $urandom_range(1) ? UNLOCK_KEY_A : UNLOCK_KEY_B);
            push_access(OP_WRITE, PORT_CRT_IDX, rand_byte());
            push_access(OP_WRITE, PORT_CRT_DATA, rand_byte());
         end
         7, 8: push_access(1'($urandom_range(1)), pick_decoded_port(), rand_byte());
         default: push_access(1'($urandom_range(1)), PORT_W'($urandom_range(1023)),
                              rand_byte());
      endcase
   endtask

   task automatic add_directed();
      push_access(OP_READ,  PORT_SUBSYS,    8'h00);  // disabled, not allowed: bus error
      push_access(OP_READ,  10'h000,        8'hFF);  // undecoded, lowest offset
      push_access(OP_WRITE, 10'h3FF,        8'hFF);  // undecoded, highest offset
      push_access(OP_READ,  10'h3FF,        8'h00);
      push_access(OP_WRITE, PORT_SEQ_IDX,   8'hFC);  // memory mode index
      push_access(OP_WRITE, PORT_SEQ_DATA,  8'h00);
      push_access(OP_WRITE, PORT_SEQ_IDX,   8'hFF);  // VGA mode index
      push_access(OP_WRITE, PORT_SEQ_DATA,  8'h7F);
      push_access(OP_WRITE, PORT_GFX_IDX,   8'hFF);
      push_access(OP_WRITE, PORT_GFX_DATA,  8'hA5);
      push_access(OP_READ,  PORT_GFX_DATA,  8'h00);
      push_access(OP_WRITE, PORT_SUBSYS,    SUBSYS_ON);
      push_access(OP_READ,  PORT_SUBSYS,    8'h00);
      push_access(OP_WRITE, PORT_ATTR,      8'h3F);  // index phase
      push_access(OP_READ,  PORT_STATUS,    8'h00);  // back to index phase
      push_access(OP_WRITE, PORT_ATTR,      8'h02);
      push_access(OP_READ,  PORT_ATTR,      8'h00);
      push_access(OP_WRITE, PORT_DAC_MASK,  DAC_MASK_ON);
      push_access(OP_WRITE, PORT_DAC_WIDX,  8'hFF);
      repeat (4) push_access(OP_WRITE, PORT_DAC_DATA, 8'h5A);  // runs past the end
      push_access(OP_WRITE, PORT_DAC_RIDX,  8'hFF);
      push_access(OP_READ,  PORT_DAC_DATA,  8'h00);
      push_access(OP_WRITE, PORT_UNLOCK,    UNLOCK_KEY_A);
      push_access(OP_WRITE, PORT_CRT_IDX,   CRT_SYS_ONE);
      push_access(OP_WRITE, PORT_CRT_DATA,  8'h77);
      push_access(OP_WRITE, PORT_DISP_MODE, UNLOCK_KEY_B);
      push_access(OP_WRITE, PORT_SUBSYS,    8'h00);
   endtask

   // queue, driver and pending list are all stable at the rising edge
   task automatic wait_idle();
      @(posedge clock);
      while (access_queue.size() != 0 || req_tvalid || pending_responses.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_host_access(bit allowed);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= {7'($urandom_range(127)), allowed};
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      host_allowed = allowed;
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = access_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {6'b0, item.write_data, item.port_offset};
            req_tuser  <= item.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      wait (pressure_go);
      @(negedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(negedge clock);
      long_hold <= 1'b0;
   end

   // monitor: predict on request, check on response
   always @(posedge clock) begin
      req_type r;
      rsp_type got, want;
      req_fired <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r.op = req_tuser;
            r.port_offset = req_tdata[9:0];
            r.write_data = req_tdata[17:10];
            pending_responses.push_back(predict_access(r));
            req_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.read_data = rsp_tdata[7:0];
            got.bus_error = rsp_tdata[8];
            got.mode_change = rsp_tdata[9];
            got.subsystem_enabled = rsp_tdata[10];
            got.vga_mode_bit = rsp_tdata[11];
            if (pending_responses.size() == 0) begin
               report_mismatch($sformatf("unexpected response 0x%04h", rsp_tdata));
            end else begin
               want = pending_responses.pop_front();
               check_field("read_data", got.read_data, want.read_data);
               check_field("bus_error", got.bus_error, want.bus_error);
               check_field("mode_change", got.mode_change, want.mode_change);
               check_field("subsystem_enabled", got.subsystem_enabled,
                           want.subsystem_enabled);
               check_field("vga_mode_bit", got.vga_mode_bit, want.vga_mode_bit);
            end
            rsp_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("vga_indexed_register_file test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int queued;
      clear_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_host_access(1'b0);
      add_directed();
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         write_host_access(phase[0] == 1'b0);
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         queued = access_queue.size();
         while (access_queue.size() - queued < RANDOM_PER_PHASE) add_random_burst();
         if (phase == 0) pressure_go = 1'b1;
         wait_idle();
      end

      repeat (10) @(negedge clock);
      if (pending_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_responses.size()));
      $display("Ran %0d requests, %0d responses, host access off and on,", req_count,
               rsp_count);
      $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
      if (err_count == 0) begin
         $display("vga_indexed_register_file test passed");
      end else begin
         $display("%0d mismatches", err_count);
         $display("vga_indexed_register_file test failed");
      end
      $finish;
   end

endmodule
